// ----- design/csvft_pkg.sv -----
package csvft_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h41;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       field_done;
        logic       line_done;
    } t_result;

    localparam t_result RES_NONE   = '{char_out: 8'h00, char_valid: 1'b0,
                                       field_done: 1'b0, line_done: 1'b0};
    localparam t_result RES_N      = '{char_out: CH_N, char_valid: 1'b1,
                                       field_done: 1'b0, line_done: 1'b0};

endpackage

// ----- design/csv_field_tokenizer.sv -----
// Splits a line of comma-separated text into fields, one byte per input item,
// with double-quote handling: quotes toggle quoted mode and are dropped, a
// doubled quote inside quotes gives one literal quote, and a comma outside
// quotes closes the field. A field that closes empty comes out as the two
// content bytes N and A. An item with closes_line set closes the last field,
// flags that result with line_done, and clears the quote and field state.
// Each input item is decoded combinationally into zero to four results,
// which are held in a four-entry result register and handed out one per
// cycle while i_ready is high; run_last marks the last result of each item.
// A new item is taken when the register is empty or its last result is
// taken, so ordinary text streams at one byte per cycle while i_ready is
// high; an item that closes an empty field holds the input until all of its
// results are out (four for a comma on an empty field that also ends the
// line on an empty field). An item that makes no result gives no output.
module csv_field_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_char_present,
    input  logic       i_closes_line,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_field_done,
    output logic       o_line_done,
    output logic       o_run_last
);
    import csvft_pkg::*;

    logic                  r_quoted;
    logic                  r_pending;
    logic                  r_has_content;
    t_result               r_slot [MAX_RESULTS];
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;

    logic                  n_quoted;
    logic                  n_pending;
    logic                  n_has_content;
    t_result               n_slot [MAX_RESULTS];
    logic [CNT_W-1:0]      n_count;

    logic                  w_accept;
    logic                  w_last;
    logic                  w_take;
    t_result               w_cur;

    // decode of one item
    always_comb begin
        t_result    e0;
        t_result    e1;
        t_result    f0;
        t_result    f1;
        logic [1:0] n1;
        logic [1:0] n2;
        logic       q1;
        logic       h1;

        e0 = RES_NONE;
        e1 = RES_NONE;
        f0 = RES_NONE;
        f1 = RES_NONE;
        n1 = 2'd0;
        n2 = 2'd0;
        q1 = r_quoted;
        n_quoted      = r_quoted;
        n_pending     = r_pending;
        n_has_content = r_has_content;

        if (i_char_present) begin
            if (r_pending && i_char_in == CH_QUOTE) begin
                n_pending     = 1'b0;
                e0            = '{char_out: CH_QUOTE, char_valid: 1'b1,
                                  field_done: 1'b0, line_done: 1'b0};
                n1            = 2'd1;
                n_has_content = 1'b1;
            end else begin
                q1        = r_pending ? 1'b0 : r_quoted;
                n_quoted  = q1;
                n_pending = 1'b0;
                if (i_char_in == CH_QUOTE) begin
                    if (q1) begin
                        n_pending = 1'b1;
                    end else begin
                        n_quoted = 1'b1;
                    end
                end else if (i_char_in == CH_COMMA && !q1) begin
                    if (r_has_content) begin
                        e0 = '{char_out: 8'h00, char_valid: 1'b0,
                               field_done: 1'b1, line_done: 1'b0};
                        n1 = 2'd1;
                    end else begin
                        e0 = RES_N;
                        e1 = '{char_out: CH_A, char_valid: 1'b1,
                               field_done: 1'b1, line_done: 1'b0};
                        n1 = 2'd2;
                    end
                    n_has_content = 1'b0;
                end else begin
                    e0            = '{char_out: i_char_in, char_valid: 1'b1,
                                      field_done: 1'b0, line_done: 1'b0};
                    n1            = 2'd1;
                    n_has_content = 1'b1;
                end
            end
        end

        h1 = n_has_content;
        if (i_closes_line) begin
            if (h1) begin
                f0 = '{char_out: 8'h00, char_valid: 1'b0,
                       field_done: 1'b1, line_done: 1'b1};
                n2 = 2'd1;
            end else begin
                f0 = RES_N;
                f1 = '{char_out: CH_A, char_valid: 1'b1,
                       field_done: 1'b1, line_done: 1'b1};
                n2 = 2'd2;
            end
            n_quoted      = 1'b0;
            n_pending     = 1'b0;
            n_has_content = 1'b0;
        end

        case (n1)
            2'd0: begin
                n_slot[0] = f0;
                n_slot[1] = f1;
                n_slot[2] = RES_NONE;
                n_slot[3] = RES_NONE;
            end
            2'd1: begin
                n_slot[0] = e0;
                n_slot[1] = f0;
                n_slot[2] = f1;
                n_slot[3] = RES_NONE;
            end
            default: begin
                n_slot[0] = e0;
                n_slot[1] = e1;
                n_slot[2] = f0;
                n_slot[3] = f1;
            end
        endcase
        n_count = CNT_W'(n1) + CNT_W'(n2);
    end

    assign w_cur    = r_slot[r_idx];
    assign o_valid  = (r_count != '0);
    assign w_last   = (r_count == (CNT_W'(r_idx) + CNT_W'(1)));
    assign w_take   = o_valid && i_ready;
    assign o_ready  = !o_valid || (i_ready && w_last);
    assign w_accept = i_valid && o_ready;

    assign o_char_out   = w_cur.char_out;
    assign o_char_valid = w_cur.char_valid;
    assign o_field_done = w_cur.field_done;
    assign o_line_done  = w_cur.line_done;
    assign o_run_last   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted      <= 1'b0;
            r_pending     <= 1'b0;
            r_has_content <= 1'b0;
            r_count       <= '0;
            r_idx         <= '0;
        end else begin
            if (w_accept) begin
                r_quoted      <= n_quoted;
                r_pending     <= n_pending;
                r_has_content <= n_has_content;
                r_count       <= n_count;
                r_idx         <= '0;
            end else if (w_take) begin
                if (w_last) begin
                    r_count <= '0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_idx_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CNT_W'(r_idx) < r_count))
        else $error("result index past count");

    a_line_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |-> (o_run_last && o_field_done))
        else $error("line close is not the last field close of its item");

    a_line_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_closes_line) |=> (!r_quoted && !r_pending && !r_has_content))
        else $error("state not cleared after line end");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

endmodule
